// ===== hdl/tkst_pkg.sv =====
// tkst_pkg: shared types for the top-k score table
// word layouts of the input and result channels, controller to datapath command and status
// no dependencies
package tkst_pkg;

    localparam int SCORE_W = 32;
    localparam int TIME_W  = 63;
    localparam int NIB_W   = 4;

    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [SCORE_W-1:0] offer_score;
        logic [TIME_W-1:0]  offer_time;
    } t_in_word;

    typedef struct packed {
        logic               accepted;
        logic [NIB_W-1:0]   rank;
        logic [NIB_W-1:0]   entry_count;
        logic               entry_valid;
        logic [SCORE_W-1:0] entry_score;
        logic [TIME_W-1:0]  entry_time;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic load_in;
        logic cmp;
        logic ins;
        logic rd;
        logic empty;
    } t_dp_cmd;

    typedef struct packed {
        logic in_action;
        logic slot_free;
        logic count_zero;
        logic rd_last;
    } t_dp_stat;

endpackage

// ===== hdl/tkst_in_if.sv =====
// tkst_in_if: valid/ready channel carrying one input word
// depends on tkst_pkg
interface tkst_in_if;
    logic              valid;
    logic              ready;
    tkst_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tkst_out_if.sv =====
// tkst_out_if: valid/ready channel carrying one result word
// depends on tkst_pkg
interface tkst_out_if;
    logic               valid;
    logic               ready;
    tkst_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tkst_ctrl.sv =====
// tkst_ctrl: sequencer for offers and read-outs
// depends on tkst_pkg, drives commands to tkst_dp
module tkst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tkst_pkg::t_dp_stat i_stat,
    output tkst_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_INS,
        S_READ,
        S_EMPTY
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   w_accept;

    assign w_accept   = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load_in = (r_state == S_IDLE) && w_accept;
        o_cmd.cmp     = (r_state == S_CMP);
        o_cmd.ins     = (r_state == S_INS) && i_stat.slot_free;
        o_cmd.rd      = (r_state == S_READ) && i_stat.slot_free;
        o_cmd.empty   = (r_state == S_EMPTY) && i_stat.slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_in_ready <= 1'b0;
                        if (i_stat.in_action == tkst_pkg::ACT_OFFER) begin
                            r_state <= S_CMP;
                        end else if (i_stat.count_zero) begin
                            r_state <= S_EMPTY;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_CMP: begin
                    r_state <= S_INS;
                end
                S_INS: begin
                    if (i_stat.slot_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                S_READ: begin
                    if (i_stat.slot_free && i_stat.rd_last) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                S_EMPTY: begin
                    if (i_stat.slot_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== hdl/tkst_dp.sv =====
// tkst_dp: row of compare-and-shift cells, offer latch and result register
// depends on tkst_pkg, commanded by tkst_ctrl
module tkst_dp #(
    parameter int TABLE_ENTRIES = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tkst_pkg::t_in_word  i_in_data,
    input  tkst_pkg::t_dp_cmd   i_cmd,
    output tkst_pkg::t_dp_stat  o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tkst_pkg::t_out_word o_out_data
);

    localparam int N   = TABLE_ENTRIES;
    localparam int CW  = $clog2(N + 1);
    localparam int CW1 = CW + 1;
    localparam int SW  = tkst_pkg::SCORE_W;
    localparam int TW  = tkst_pkg::TIME_W;
    localparam int NW  = tkst_pkg::NIB_W;

    logic [SW-1:0] r_score [N];
    logic [TW-1:0] r_time  [N];
    logic [SW-1:0] n_score [N];
    logic [TW-1:0] n_time  [N];
    logic [N-1:0]  r_ge;
    logic [N-1:0]  n_ge;
    logic [N-1:0]  w_bound;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_idx;
    logic [SW-1:0] r_off_score;
    logic [TW-1:0] r_off_time;
    logic          w_reject;
    logic [CW-1:0] w_pos;
    logic          w_rd_last;
    logic          w_slot_free;

    logic                r_out_valid;
    tkst_pkg::t_out_word r_out;
    tkst_pkg::t_out_word n_out;

    assign w_reject    = r_ge[N-1];
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_rd_last   = (CW1'(r_idx) + CW1'(1)) == CW1'(r_count);

    assign o_stat.in_action  = i_in_data.action;
    assign o_stat.slot_free  = w_slot_free;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.rd_last    = w_rd_last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // per cell compare, insert and rotate
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            assign n_ge[g] = (CW'(g) < r_count) && (r_score[g] >= r_off_score);

            if (g == 0) begin : g_head
                assign w_bound[g] = !r_ge[g];
            end else begin : g_body
                assign w_bound[g] = !r_ge[g] && r_ge[g-1];
            end

            always_comb begin
                n_score[g] = r_score[g];
                n_time[g]  = r_time[g];
                if (i_cmd.ins) begin
                    if (w_bound[g]) begin
                        n_score[g] = r_off_score;
                        n_time[g]  = r_off_time;
                    end else if (g > 0 && !r_ge[g]) begin
                        n_score[g] = r_score[(g > 0) ? g - 1 : 0];
                        n_time[g]  = r_time[(g > 0) ? g - 1 : 0];
                    end
                end else if (i_cmd.rd) begin
                    if (g < N - 1 && (CW1'(g) + CW1'(1)) < CW1'(r_count)) begin
                        n_score[g] = r_score[(g < N - 1) ? g + 1 : g];
                        n_time[g]  = r_time[(g < N - 1) ? g + 1 : g];
                    end else if ((CW1'(g) + CW1'(1)) == CW1'(r_count)) begin
                        n_score[g] = r_score[0];
                        n_time[g]  = r_time[0];
                    end
                end
            end
        end
    endgenerate

    // index of the insertion point
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < N; i++) begin
            if (w_bound[i]) begin
                w_pos = w_pos | CW'(i);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.ins && !w_reject && r_count < CW'(N)) begin
            n_count = r_count + CW'(1);
        end
    end

    always_comb begin
        n_out = '0;
        if (i_cmd.ins) begin
            n_out.accepted    = !w_reject;
            n_out.rank        = w_reject ? NW'(N) : NW'(w_pos);
            n_out.entry_count = NW'(n_count);
            n_out.last        = 1'b1;
        end else if (i_cmd.rd) begin
            n_out.rank        = NW'(r_idx);
            n_out.entry_count = NW'(r_count);
            n_out.entry_valid = 1'b1;
            n_out.entry_score = r_score[0];
            n_out.entry_time  = r_time[0];
            n_out.last        = w_rd_last;
        end else begin
            n_out.last        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.ins || i_cmd.rd || i_cmd.empty) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load_in) begin
                r_idx <= '0;
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_off_score <= i_in_data.offer_score;
            r_off_time  <= i_in_data.offer_time;
        end
        if (i_cmd.cmp) begin
            r_ge <= n_ge;
        end
        if (i_cmd.ins || i_cmd.rd || i_cmd.empty) begin
            r_out <= n_out;
        end
        for (int i = 0; i < N; i++) begin
            r_score[i] <= n_score[i];
            r_time[i]  <= n_time[i];
        end
    end

endmodule

// ===== hdl/top_k_score_table_top.sv =====
// top_k_score_table_top: top-k sorted score table, controller plus cell-row datapath
// depends on tkst_pkg, tkst_in_if, tkst_out_if, tkst_ctrl, tkst_dp
// offer: latched on accept, compare in S_CMP, result word in S_INS; next input taken only after S_INS
// read-out of n entries: n words from S_READ, one per cycle while the sink does not stall
// empty read-out: one word from S_EMPTY; sink stalls add cycle for cycle
// reset (synchronous, active low) empties the table and drops any pending result word
module top_k_score_table_top #(
    parameter int TABLE_ENTRIES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkst_in_if.sink     i_in,
    tkst_out_if.source  o_out
);

    tkst_pkg::t_dp_cmd  w_cmd;
    tkst_pkg::t_dp_stat w_stat;

    tkst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tkst_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

endmodule
